/* rtl/qlce_pkg.sv */
// Shared types, codes and character set tables of the quoted literal encoder.
package qlce_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] CHARSET_ASCII = 3'd0;
    localparam logic [2:0] CHARSET_PET   = 3'd1;
    localparam logic [2:0] CHARSET_LOWER = 3'd2;
    localparam logic [2:0] CHARSET_UPPER = 3'd3;

    localparam logic [1:0] END_PLAIN = 2'd0;
    localparam logic [1:0] END_ZERO  = 2'd1;
    localparam logic [1:0] END_MARK  = 2'd2;

    localparam logic [0:0] CFG_CHARSET = 1'd0;
    localparam logic [0:0] CFG_END     = 1'd1;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] MARK_BIT   = 8'h80;

    typedef enum logic {
        PH_AWAIT  = 1'b0,
        PH_INSIDE = 1'b1
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       out_last;
        logic       unterminated;
    } t_result;

    localparam logic [7:0] PET_ROM [128] = '{
        8'h20,8'h20,8'h20,8'hd3,8'hda,8'hd8,8'hc1,8'hd1,
        8'hd1,8'h77,8'h20,8'h20,8'h20,8'h20,8'h20,8'h2a,
        8'h20,8'h20,8'h20,8'h21,8'h20,8'h20,8'haf,8'h20,
        8'h5e,8'h20,8'h20,8'h5f,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,
        8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'h2e,8'h2f,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
        8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,
        8'h40,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
        8'hc8,8'hc9,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,
        8'hd0,8'hd1,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,
        8'hd8,8'hd9,8'hda,8'h5b,8'h20,8'h5d,8'h5e,8'h5f,
        8'h20,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
        8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,
        8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
        8'h58,8'h59,8'h5a,8'h27,8'hdd,8'h28,8'h20,8'h20
    };

    localparam logic [7:0] LOWER_ROM [128] = '{
        8'h00,8'h00,8'h00,8'h53,8'h5a,8'h58,8'h41,8'h51,
        8'hd1,8'h57,8'hd7,8'h20,8'h20,8'h20,8'h20,8'h2a,
        8'h20,8'h20,8'h20,8'h21,8'h20,8'h20,8'h79,8'h20,
        8'h1e,8'h20,8'h20,8'h1f,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,
        8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'h2e,8'h2f,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
        8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,
        8'h00,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
        8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,
        8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
        8'h58,8'h59,8'h5a,8'h1b,8'h20,8'h1d,8'h1e,8'h64,
        8'h20,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
        8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,
        8'h18,8'h19,8'h1a,8'h28,8'h42,8'h29,8'h20,8'h20
    };

    localparam logic [7:0] UPPER_ROM [128] = '{
        8'h00,8'h00,8'h00,8'h53,8'h5a,8'h58,8'h41,8'h51,
        8'hd1,8'h57,8'hd7,8'h20,8'h20,8'h20,8'h20,8'h2a,
        8'h20,8'h20,8'h20,8'h21,8'h20,8'h20,8'h79,8'h20,
        8'h1e,8'h20,8'h20,8'h1f,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,
        8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'h2e,8'h2f,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
        8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
        8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,
        8'h18,8'h19,8'h1a,8'h1b,8'h20,8'h1d,8'h1e,8'h64,
        8'h20,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
        8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,
        8'h18,8'h19,8'h1a,8'h28,8'h42,8'h29,8'h20,8'h20
    };

    function automatic logic [7:0] translate(input logic [2:0] charset, input logic [7:0] ch);
        logic [7:0] b;
        unique case (charset)
            CHARSET_ASCII: b = ch;
            CHARSET_PET:   b = PET_ROM[ch[6:0]];
            CHARSET_LOWER: b = LOWER_ROM[ch[6:0]];
            CHARSET_UPPER: b = UPPER_ROM[ch[6:0]];
            default:       b = SPACE_CHAR;
        endcase
        return b;
    endfunction

endpackage

/* rtl/quoted_literal_charset_encoder.sv */
// Quoted literal encoder: delimiter tracking, charset translation and result queue.
//
// Usage: source characters enter on the request channel (i_valid / o_ready) with
// i_text_char and i_text_end; encoded bytes leave on the result channel
// (o_valid / i_ready) with o_out_byte, o_is_data, o_out_last, o_unterminated.
// The first character of a literal is its delimiter; one output byte is held
// back until the next request shows whether the literal closes.
// Throughput: one request per cycle while o_ready is high. Each request is decoded
// in the cycle it is accepted and pushes zero, one or two results into a 4-entry
// result queue; results reach the output from the queue registers.
// o_ready is high while the queue has room for two results, so a stalled receiver
// backs up the request channel after at most four queued results.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data): index 0 selects the charset,
// index 1 the end mode; writes take effect at once and belong to idle periods.
// Reset (synchronous, active low) clears the configuration, the literal state and
// the result queue; the block then awaits an opening delimiter.
module quoted_literal_charset_encoder
    import qlce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_char,
    input  logic       i_text_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_out_last,
    output logic       o_unterminated,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [2:0] i_cfg_data
);

    logic [2:0] r_charset;
    logic [1:0] r_end_mode;
    t_phase     r_phase, n_phase;
    logic [7:0] r_delim, n_delim;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_valid, n_held_valid;
    logic       r_held_markable, n_held_markable;
    logic       r_delim_seen, n_delim_seen;

    t_result    r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic       accept, pop;
    logic [1:0] push_n;
    t_result    res0, res1;
    t_result    held_res, zero_res, bare_res;
    logic       fin_unterm;
    logic [7:0] trans;

    assign accept = i_valid && o_ready;
    assign pop    = o_valid && i_ready;
    assign o_ready = r_count <= CNT_W'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign trans   = translate(r_charset, i_text_char);
    assign fin_unterm = i_text_end && !r_delim_seen;

    always_comb begin
        held_res = '{out_byte: r_held_byte, is_data: 1'b1, out_last: 1'b0,
                     unterminated: 1'b0};
        zero_res = '{out_byte: 8'h00, is_data: 1'b1, out_last: 1'b0, unterminated: 1'b0};
        bare_res = '{out_byte: 8'h00, is_data: 1'b0, out_last: 1'b0, unterminated: 1'b0};

        n_phase         = r_phase;
        n_delim         = r_delim;
        n_held_byte     = r_held_byte;
        n_held_valid    = r_held_valid;
        n_held_markable = r_held_markable;
        n_delim_seen    = r_delim_seen;
        push_n          = 2'd0;
        res0            = held_res;
        res1            = zero_res;

        if (accept) begin
            if (r_phase == PH_AWAIT) begin
                if (!i_text_end) begin
                    n_delim = i_text_char;
                    n_phase = PH_INSIDE;
                end
            end else if (i_text_end || (r_delim_seen && i_text_char != r_delim)) begin
                if (r_end_mode == END_MARK && r_held_markable) begin
                    res0.out_byte = r_held_byte | MARK_BIT;
                end
                if (r_held_valid) begin
                    push_n = (r_end_mode == END_ZERO) ? 2'd2 : 2'd1;
                end else if (r_end_mode == END_ZERO) begin
                    res0   = zero_res;
                    push_n = 2'd1;
                end else if (fin_unterm) begin
                    res0   = bare_res;
                    push_n = 2'd1;
                end
                if (push_n == 2'd2) begin
                    res1.out_last     = 1'b1;
                    res1.unterminated = fin_unterm;
                end else begin
                    res0.out_last     = 1'b1;
                    res0.unterminated = fin_unterm;
                end
                n_held_byte     = 8'h00;
                n_held_valid    = 1'b0;
                n_held_markable = 1'b0;
                n_delim_seen    = 1'b0;
                if (i_text_end) begin
                    n_phase = PH_AWAIT;
                end else begin
                    n_phase = PH_INSIDE;
                    n_delim = i_text_char;
                end
            end else if (r_delim_seen) begin
                push_n          = {1'b0, r_held_valid};
                n_held_byte     = r_delim;
                n_held_valid    = 1'b1;
                n_held_markable = 1'b0;
                n_delim_seen    = 1'b0;
            end else if (i_text_char == r_delim) begin
                n_delim_seen = 1'b1;
            end else begin
                push_n          = {1'b0, r_held_valid};
                n_held_byte     = trans;
                n_held_valid    = 1'b1;
                n_held_markable = 1'b1;
            end
        end

        n_count = r_count + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset       <= CHARSET_ASCII;
            r_end_mode      <= END_PLAIN;
            r_phase         <= PH_AWAIT;
            r_delim         <= 8'h00;
            r_held_byte     <= 8'h00;
            r_held_valid    <= 1'b0;
            r_held_markable <= 1'b0;
            r_delim_seen    <= 1'b0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHARSET: r_charset  <= i_cfg_data;
                    CFG_END:     r_end_mode <= i_cfg_data[1:0];
                    default:     r_charset  <= r_charset;
                endcase
            end
            r_phase         <= n_phase;
            r_delim         <= n_delim;
            r_held_byte     <= n_held_byte;
            r_held_valid    <= n_held_valid;
            r_held_markable <= n_held_markable;
            r_delim_seen    <= n_delim_seen;
            r_wr_ptr        <= r_wr_ptr + PTR_W'(push_n);
            r_rd_ptr        <= r_rd_ptr + PTR_W'(pop);
            r_count         <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    assign o_out_byte     = r_fifo[r_rd_ptr].out_byte;
    assign o_is_data      = r_fifo[r_rd_ptr].is_data;
    assign o_out_last     = r_fifo[r_rd_ptr].out_last;
    assign o_unterminated = r_fifo[r_rd_ptr].unterminated;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_await_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_AWAIT) |=> r_count <= $past(r_count))
        else $error("result pushed while awaiting a delimiter");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> r_count >= $past(r_count))
        else $error("queued result lost under stall");

    a_markable_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_markable |-> r_held_valid)
        else $error("markable flag without a held byte");

    a_seen_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delim_seen |-> (r_phase == PH_INSIDE))
        else $error("pending delimiter outside a literal");

endmodule
